// ===== hw/rtl/yafp_pkg.sv =====
// shared types, coefficients and helper functions for the yuv alpha fade pixel unit
package yafp_pkg;

  // forward conversion coefficients, value times 65536, rounded
  localparam logic signed [18:0] K_Y2C = 19'sd76309;
  localparam logic signed [18:0] K_V2R = 19'sd104597;
  localparam logic signed [18:0] K_U2G = 19'sd25675;
  localparam logic signed [18:0] K_V2G = 19'sd53279;
  localparam logic signed [18:0] K_U2B = 19'sd132201;

  // back conversion coefficients, value times 65536, rounded
  localparam logic [15:0] K_R2Y = 16'd16829;
  localparam logic [15:0] K_G2Y = 16'd33039;
  localparam logic [15:0] K_B2Y = 16'd6416;
  localparam logic [15:0] K_R2U = 16'd9714;
  localparam logic [15:0] K_G2U = 16'd19071;
  localparam logic [15:0] K_B2U = 16'd28784;
  localparam logic [15:0] K_R2V = 16'd28784;
  localparam logic [15:0] K_G2V = 16'd24103;
  localparam logic [15:0] K_B2V = 16'd4681;

  localparam int unsigned ALPHA_W = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd255;

  typedef logic signed [27:0] fwd_sum_t;
  typedef logic [23:0]        back_prod_t;
  typedef logic signed [25:0] back_sum_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  // negative goes to 0, anything at or above 256 after the shift goes to 255
  function automatic logic [7:0] clamp_chan(fwd_sum_t s);
    logic [7:0] c;
    if (s[27]) begin
      c = 8'd0;
    end else if (|s[26:24]) begin
      c = 8'd255;
    end else begin
      c = s[23:16];
    end
    return c;
  endfunction

  function automatic logic [7:0] back_chan(back_sum_t s);
    logic [7:0] c;
    if (s[25]) begin
      c = 8'd0;
    end else begin
      c = s[23:16];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/yafp_in_if.sv =====
// input pixel channel: valid, ready and yuv payload
interface yafp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_in;
  logic [7:0] blue_diff_in;
  logic [7:0] red_diff_in;

  modport source (output valid, output luma_in, output blue_diff_in, output red_diff_in,
                  input ready);
  modport sink (input valid, input luma_in, input blue_diff_in, input red_diff_in,
                output ready);
endinterface

// ===== hw/rtl/yafp_out_if.sv =====
// output pixel channel: valid, ready and faded yuv payload
interface yafp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;
  logic [7:0] blue_diff_out;
  logic [7:0] red_diff_out;

  modport source (output valid, output luma_out, output blue_diff_out, output red_diff_out,
                  input ready);
  modport sink (input valid, input luma_out, input blue_diff_out, input red_diff_out,
                output ready);
endinterface

// ===== hw/rtl/yuv_alpha_fade_pixel_unit.sv =====
// top level of the yuv alpha fade pixel unit
// Fades a 4:4:4 YUV pixel stream toward black. Each pixel is turned into
// limited-range BT.601 RGB with each channel clamped to 0..255, every channel
// is scaled by the fade alpha as (c * alpha) >> 8, and the result goes back
// to YUV with the sums floored, so outputs stay within 16..240. The unit takes
// one pixel per clock while the output is taken and holds five pixels in
// flight, one in each of five register stages (forward products, forward
// sums and clamp, fade multiply, back products, back sums into the output
// register). Each stage moves on its own when the stage ahead is empty or
// moving, so bubbles fill in during a stall and a held output does not stop
// input transfers until the pipe is full. The fade alpha resets to 255 and
// must only be written while no pixel is in flight.
module yuv_alpha_fade_pixel_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [yafp_pkg::ALPHA_W-1:0] cfg_wr_data,
  yafp_in_if.sink                      pixel,
  yafp_out_if.source                   faded
);

  // fade register
  logic [yafp_pkg::ALPHA_W-1:0] fade_alpha;

  // inter-module channels
  yafp_pkg::yuv_t in_pix;
  logic           rgb_valid;
  logic           rgb_ready;
  yafp_pkg::rgb_t rgb_pix;
  logic           fade_valid;
  logic           fade_ready;
  yafp_pkg::rgb_t fade_pix;
  yafp_pkg::yuv_t out_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_alpha <= yafp_pkg::ALPHA_RESET;
    end else if (cfg_wr_en) begin
      fade_alpha <= cfg_wr_data;
    end
  end

  assign in_pix.y = pixel.luma_in;
  assign in_pix.u = pixel.blue_diff_in;
  assign in_pix.v = pixel.red_diff_in;

  // stages one and two: yuv to clamped rgb
  yafp_to_rgb u_to_rgb (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel.valid),
    .up_ready (pixel.ready),
    .up_pix   (in_pix),
    .dn_valid (rgb_valid),
    .dn_ready (rgb_ready),
    .dn_pix   (rgb_pix)
  );

  // stage three: alpha scale
  yafp_fade u_fade (
    .clk      (clk),
    .rst      (rst),
    .alpha    (fade_alpha),
    .up_valid (rgb_valid),
    .up_ready (rgb_ready),
    .up_pix   (rgb_pix),
    .dn_valid (fade_valid),
    .dn_ready (fade_ready),
    .dn_pix   (fade_pix)
  );

  // stages four and five: back to yuv, last stage is the output register
  yafp_to_yuv u_to_yuv (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fade_valid),
    .up_ready (fade_ready),
    .up_pix   (fade_pix),
    .dn_valid (faded.valid),
    .dn_ready (faded.ready),
    .dn_pix   (out_pix)
  );

  assign faded.luma_out      = out_pix.y;
  assign faded.blue_diff_out = out_pix.u;
  assign faded.red_diff_out  = out_pix.v;

  // input only backs up when the output holds a pixel that is not taken
  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (faded.valid && !faded.ready))
    else $error("input stalled while output is free");

  // nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !faded.valid)
    else $error("output valid right after reset");

  // back conversion of any faded rgb value (each channel at most 254) lands inside 16..240
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    faded.valid |-> (faded.luma_out >= 8'd16 && faded.luma_out <= 8'd240))
    else $error("luma out of range");

  a_chroma_range: assert property (@(posedge clk) disable iff (rst)
    faded.valid |-> (faded.blue_diff_out >= 8'd16 && faded.blue_diff_out <= 8'd240
                     && faded.red_diff_out >= 8'd16 && faded.red_diff_out <= 8'd240))
    else $error("chroma out of range");

endmodule

// ===== hw/rtl/yafp_to_rgb.sv =====
// yuv to clamped rgb: product stage then sum and clamp stage
module yafp_to_rgb (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  yafp_pkg::yuv_t      up_pix,
  output logic                dn_valid,
  input  logic                dn_ready,
  output yafp_pkg::rgb_t      dn_pix
);

  logic signed [8:0] y_d;
  logic signed [8:0] u_d;
  logic signed [8:0] v_d;

  logic               v1;
  logic               en1;
  yafp_pkg::fwd_sum_t p_yc;
  yafp_pkg::fwd_sum_t p_vr;
  yafp_pkg::fwd_sum_t p_ug;
  yafp_pkg::fwd_sum_t p_vg;
  yafp_pkg::fwd_sum_t p_ub;

  logic               v2;
  logic               en2;
  yafp_pkg::fwd_sum_t r_sum;
  yafp_pkg::fwd_sum_t g_sum;
  yafp_pkg::fwd_sum_t b_sum;
  yafp_pkg::rgb_t     rgb;

  assign en2      = !v2 || dn_ready;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  // remove the video offsets
  assign y_d = $signed({1'b0, up_pix.y}) - 9'sd16;
  assign u_d = $signed({1'b0, up_pix.u}) - 9'sd128;
  assign v_d = $signed({1'b0, up_pix.v}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p_yc <= yafp_pkg::fwd_sum_t'(yafp_pkg::K_Y2C) * yafp_pkg::fwd_sum_t'(y_d);
      p_vr <= yafp_pkg::fwd_sum_t'(yafp_pkg::K_V2R) * yafp_pkg::fwd_sum_t'(v_d);
      p_ug <= yafp_pkg::fwd_sum_t'(yafp_pkg::K_U2G) * yafp_pkg::fwd_sum_t'(u_d);
      p_vg <= yafp_pkg::fwd_sum_t'(yafp_pkg::K_V2G) * yafp_pkg::fwd_sum_t'(v_d);
      p_ub <= yafp_pkg::fwd_sum_t'(yafp_pkg::K_U2B) * yafp_pkg::fwd_sum_t'(u_d);
    end
  end

  assign r_sum = p_yc + p_vr;
  assign g_sum = p_yc - p_ug - p_vg;
  assign b_sum = p_yc + p_ub;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rgb.r <= yafp_pkg::clamp_chan(r_sum);
      rgb.g <= yafp_pkg::clamp_chan(g_sum);
      rgb.b <= yafp_pkg::clamp_chan(b_sum);
    end
  end

  assign dn_valid = v2;
  assign dn_pix   = rgb;

endmodule

// ===== hw/rtl/yafp_fade.sv =====
// per-channel alpha scale, (c * alpha) >> 8
module yafp_fade (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [yafp_pkg::ALPHA_W-1:0]   alpha,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  yafp_pkg::rgb_t                 up_pix,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output yafp_pkg::rgb_t                 dn_pix
);

  logic           v3;
  logic           en3;
  logic [15:0]    r_prod;
  logic [15:0]    g_prod;
  logic [15:0]    b_prod;
  yafp_pkg::rgb_t faded;

  assign en3      = !v3 || dn_ready;
  assign up_ready = en3;

  assign r_prod = 16'(up_pix.r) * 16'(alpha);
  assign g_prod = 16'(up_pix.g) * 16'(alpha);
  assign b_prod = 16'(up_pix.b) * 16'(alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      faded.r <= r_prod[15:8];
      faded.g <= g_prod[15:8];
      faded.b <= b_prod[15:8];
    end
  end

  assign dn_valid = v3;
  assign dn_pix   = faded;

endmodule

// ===== hw/rtl/yafp_to_yuv.sv =====
// rgb back to yuv: product stage then sum stage into the output register
module yafp_to_yuv (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  yafp_pkg::rgb_t up_pix,
  output logic           dn_valid,
  input  logic           dn_ready,
  output yafp_pkg::yuv_t dn_pix
);

  logic                 v4;
  logic                 en4;
  yafp_pkg::back_prod_t p_ry;
  yafp_pkg::back_prod_t p_gy;
  yafp_pkg::back_prod_t p_by;
  yafp_pkg::back_prod_t p_ru;
  yafp_pkg::back_prod_t p_gu;
  yafp_pkg::back_prod_t p_bu;
  yafp_pkg::back_prod_t p_rv;
  yafp_pkg::back_prod_t p_gv;
  yafp_pkg::back_prod_t p_bv;

  logic                 v5;
  logic                 en5;
  yafp_pkg::back_sum_t  y_sum;
  yafp_pkg::back_sum_t  u_sum;
  yafp_pkg::back_sum_t  v_sum;
  yafp_pkg::yuv_t       yuv;

  assign en5      = !v5 || dn_ready;
  assign en4      = !v4 || en5;
  assign up_ready = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      p_ry <= yafp_pkg::back_prod_t'(up_pix.r) * yafp_pkg::back_prod_t'(yafp_pkg::K_R2Y);
      p_gy <= yafp_pkg::back_prod_t'(up_pix.g) * yafp_pkg::back_prod_t'(yafp_pkg::K_G2Y);
      p_by <= yafp_pkg::back_prod_t'(up_pix.b) * yafp_pkg::back_prod_t'(yafp_pkg::K_B2Y);
      p_ru <= yafp_pkg::back_prod_t'(up_pix.r) * yafp_pkg::back_prod_t'(yafp_pkg::K_R2U);
      p_gu <= yafp_pkg::back_prod_t'(up_pix.g) * yafp_pkg::back_prod_t'(yafp_pkg::K_G2U);
      p_bu <= yafp_pkg::back_prod_t'(up_pix.b) * yafp_pkg::back_prod_t'(yafp_pkg::K_B2U);
      p_rv <= yafp_pkg::back_prod_t'(up_pix.r) * yafp_pkg::back_prod_t'(yafp_pkg::K_R2V);
      p_gv <= yafp_pkg::back_prod_t'(up_pix.g) * yafp_pkg::back_prod_t'(yafp_pkg::K_G2V);
      p_bv <= yafp_pkg::back_prod_t'(up_pix.b) * yafp_pkg::back_prod_t'(yafp_pkg::K_B2V);
    end
  end

  // offsets 16 and 128 in 16.16 fixed point
  assign y_sum = 26'sd1048576 + $signed({2'b00, p_ry}) + $signed({2'b00, p_gy})
               + $signed({2'b00, p_by});
  assign u_sum = 26'sd8388608 - $signed({2'b00, p_ru}) - $signed({2'b00, p_gu})
               + $signed({2'b00, p_bu});
  assign v_sum = 26'sd8388608 + $signed({2'b00, p_rv}) - $signed({2'b00, p_gv})
               - $signed({2'b00, p_bv});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      yuv.y <= yafp_pkg::back_chan(y_sum);
      yuv.u <= yafp_pkg::back_chan(u_sum);
      yuv.v <= yafp_pkg::back_chan(v_sum);
    end
  end

  assign dn_valid = v5;
  assign dn_pix   = yuv;

endmodule
